// ===== rtl/core/fjt_pkg.sv =====
// ----------------------------------------------------------------------------
// fjt_pkg
// Shared types, codes and character helpers for the flat JSON list/map
// tokenizer.
// ----------------------------------------------------------------------------
package fjt_pkg;

  // default width of the saturating element counter
  localparam int COUNT_WIDTH_DEF = 16;
  // width of the element count on the result port
  localparam int OUT_COUNT_W     = 16;
  // result bundles held between front and back
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);
  // most results one byte can cause
  localparam int MAX_RES         = 3;

  // parser phase
  typedef enum logic [3:0] {
    PH_START = 4'd0,
    PH_ELEM  = 4'd1,
    PH_VAL   = 4'd2,
    PH_STR   = 4'd3,
    PH_ESC   = 4'd4,
    PH_HEX   = 4'd5,
    PH_TOK   = 4'd6,
    PH_AKEY  = 4'd7,
    PH_AVAL  = 4'd8,
    PH_DEAD  = 4'd9
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_KEY    = 2'd1;
  localparam logic [1:0] KIND_ELEM   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_SHORT      = 4'd1;
  localparam logic [3:0] ST_BAD_START  = 4'd2;
  localparam logic [3:0] ST_BAD_END    = 4'd3;
  localparam logic [3:0] ST_STRAY_COMMA = 4'd4;
  localparam logic [3:0] ST_LONE_BSLASH = 4'd5;
  localparam logic [3:0] ST_SHORT_UNI  = 4'd6;
  localparam logic [3:0] ST_BAD_ESC    = 4'd7;
  localparam logic [3:0] ST_UNCLOSED   = 4'd8;
  localparam logic [3:0] ST_NO_COLON   = 4'd9;
  localparam logic [3:0] ST_NO_COMMA   = 4'd10;

  // characters
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  // one request's worth of results, at most three
  typedef struct packed {
    logic [1:0]                    n;
    logic [MAX_RES-1:0][1:0]       kind;
    logic [MAX_RES-1:0][7:0]       data;
    logic [3:0]                    status;
    logic [OUT_COUNT_W-1:0]        count;
  } bundle_t;

  // queue fill flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F) || (c == 8'h2D) ||
           (c == 8'h2E);
  endfunction

  // bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
      return {1'b1, v[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
      return {1'b1, v[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  // bit 8 flags a simple escape, bits 7:0 hold the decoded byte
  function automatic logic [8:0] esc_decode(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h5C:   r = {1'b1, 8'h5C};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h74:   r = {1'b1, 8'h09};
      8'h72:   r = {1'b1, 8'h0D};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h66:   r = {1'b1, 8'h0C};
      8'h62:   r = {1'b1, 8'h08};
      8'h22:   r = {1'b1, 8'h22};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/fjt_front.sv =====
// ----------------------------------------------------------------------------
// fjt_front
// Parser front end: takes one text byte per request, tracks the parse phase
// and builds the bundle of results that the byte causes.
// ----------------------------------------------------------------------------
module fjt_front #(
  parameter int COUNT_WIDTH = fjt_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_data,
  input  logic             accept,
  input  logic [7:0]       text_byte,
  input  logic             final_byte,
  output logic             push,
  output fjt_pkg::bundle_t bundle
);
  import fjt_pkg::*;

  // state
  phase_t                 phase, phase_next;
  logic                   map_mode;
  logic                   single_quoted, single_quoted_next;
  logic [1:0]             hex_cnt, hex_cnt_next;
  logic [15:0]            hex_value, hex_value_next;
  logic                   start_bad, start_bad_next;
  logic [3:0]             first_error, first_error_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  logic                   in_key, in_key_next;

  // decode
  logic                   sp, tk, hx, is_q;
  logic [4:0]             hex_dec;
  logic [8:0]             esc_dec;
  logic [7:0]             lq, rq;
  logic                   in_begin, begin_quote, begin_tok, do_after, key_sel;
  logic                   key_colon, val_comma;
  logic                   hex_last;
  logic [15:0]            uni;
  logic                   live, start_step, fin_step;
  logic                   fin_elem;
  logic [3:0]             fin_status;
  logic [COUNT_WIDTH-1:0] count_inc, count_fin;
  logic [COUNT_WIDTH+OUT_COUNT_W-1:0] count_ext;

  // byte classes and shared decisions
  always_comb begin
    sp       = is_space(text_byte);
    tk       = is_token(text_byte);
    hex_dec  = hex_decode(text_byte);
    hx       = hex_dec[4];
    esc_dec  = esc_decode(text_byte);
    is_q     = text_byte == (single_quoted ? CH_SQUOTE : CH_DQUOTE);
    lq       = map_mode ? CH_LBRACE : CH_LBRACK;
    rq       = map_mode ? CH_RBRACE : CH_RBRACK;

    start_step = accept && (phase == PH_START);
    fin_step   = accept && (phase != PH_START) && final_byte;
    live       = accept && (phase != PH_START) && !final_byte && (phase != PH_DEAD);

    in_begin    = ((phase == PH_ELEM) && !sp && (text_byte != CH_COMMA)) ||
                  ((phase == PH_VAL) && !sp);
    begin_quote = in_begin && ((text_byte == CH_DQUOTE) || (text_byte == CH_SQUOTE));
    begin_tok   = in_begin && !begin_quote && tk;
    do_after    = (in_begin && !begin_quote && !tk) || ((phase == PH_TOK) && !tk) ||
                  (phase == PH_AKEY) || (phase == PH_AVAL);
    if (in_begin) begin
      key_sel = (phase == PH_ELEM) ? map_mode : 1'b0;
    end else if (phase == PH_AKEY) begin
      key_sel = 1'b1;
    end else if (phase == PH_AVAL) begin
      key_sel = 1'b0;
    end else begin
      key_sel = in_key;
    end
    key_colon = do_after && key_sel && (text_byte == CH_COLON);
    val_comma = do_after && !key_sel && (text_byte == CH_COMMA);

    hex_last = (phase == PH_HEX) && hx && (hex_cnt == 2'd3);
    uni      = {hex_value[11:0], hex_dec[3:0]};

    count_inc = (count == {COUNT_WIDTH{1'b1}}) ? count : count + 1'b1;

    // end of document checks, in priority order
    fin_elem   = 1'b0;
    fin_status = first_error;
    if (start_bad) begin
      fin_status = ST_BAD_START;
    end else if (text_byte != rq) begin
      fin_status = ST_BAD_END;
    end else begin
      case (phase)
        PH_STR:  fin_status = ST_UNCLOSED;
        PH_ESC:  fin_status = ST_LONE_BSLASH;
        PH_HEX:  fin_status = ST_SHORT_UNI;
        PH_TOK:  begin
          if (in_key) fin_status = ST_NO_COLON;
          else fin_elem = 1'b1;
        end
        PH_AKEY: fin_status = ST_NO_COLON;
        PH_AVAL: fin_elem = 1'b1;
        PH_VAL:  fin_elem = 1'b1;
        default: fin_status = first_error;
      endcase
    end
    count_fin = fin_elem ? count_inc : count;
    count_ext = {{OUT_COUNT_W{1'b0}}, count_fin};
  end

  // next state
  always_comb begin
    phase_next         = phase;
    single_quoted_next = single_quoted;
    hex_cnt_next       = hex_cnt;
    hex_value_next     = hex_value;
    start_bad_next     = start_bad;
    first_error_next   = first_error;
    count_next         = count;
    in_key_next        = in_key;

    if (start_step && !final_byte) begin
      if (text_byte != lq) begin
        start_bad_next = 1'b1;
        phase_next     = PH_DEAD;
      end else begin
        count_next       = '0;
        first_error_next = ST_OK;
        in_key_next      = 1'b0;
        phase_next       = PH_ELEM;
      end
    end else if (fin_step) begin
      // ready for the next document
      phase_next         = PH_START;
      single_quoted_next = 1'b0;
      hex_cnt_next       = 2'd0;
      hex_value_next     = 16'd0;
      start_bad_next     = 1'b0;
      first_error_next   = ST_OK;
      count_next         = '0;
      in_key_next        = 1'b0;
    end else if (live) begin
      case (phase)
        PH_ELEM: begin
          if (!sp && (text_byte == CH_COMMA)) begin
            first_error_next = ST_STRAY_COMMA;
            phase_next       = PH_DEAD;
          end
        end
        PH_STR: begin
          if (is_q) phase_next = in_key ? PH_AKEY : PH_AVAL;
          else if (text_byte == CH_BSLASH) phase_next = PH_ESC;
        end
        PH_ESC: begin
          if (text_byte == CH_LOW_U) begin
            hex_cnt_next   = 2'd0;
            hex_value_next = 16'd0;
            phase_next     = PH_HEX;
          end else if (esc_dec[8]) begin
            phase_next = PH_STR;
          end else begin
            first_error_next = ST_BAD_ESC;
            phase_next       = PH_DEAD;
          end
        end
        PH_HEX: begin
          if (!hx) begin
            first_error_next = ST_SHORT_UNI;
            phase_next       = PH_DEAD;
          end else begin
            hex_value_next = uni;
            hex_cnt_next   = hex_cnt + 2'd1;
            if (hex_last) phase_next = PH_STR;
          end
        end
        default: phase_next = phase;
      endcase

      // element opening
      if (begin_quote) begin
        single_quoted_next = (text_byte == CH_SQUOTE);
        in_key_next        = key_sel;
        phase_next         = PH_STR;
      end else if (begin_tok) begin
        in_key_next = key_sel;
        phase_next  = PH_TOK;
      end

      // separator after a key or an element
      if (do_after) begin
        in_key_next = key_sel;
        if (key_sel) begin
          if (sp) begin
            phase_next = PH_AKEY;
          end else if (key_colon) begin
            in_key_next = 1'b0;
            phase_next  = PH_VAL;
          end else begin
            first_error_next = ST_NO_COLON;
            phase_next       = PH_DEAD;
          end
        end else begin
          if (sp) begin
            phase_next = PH_AVAL;
          end else if (val_comma) begin
            count_next = count_inc;
            phase_next = PH_ELEM;
          end else begin
            first_error_next = ST_NO_COMMA;
            phase_next       = PH_DEAD;
          end
        end
      end
    end
  end

  // result bundle for this byte
  always_comb begin
    bundle = '0;
    if (start_step && final_byte) begin
      bundle.n       = 2'd1;
      bundle.kind[0] = KIND_STATUS;
      bundle.status  = ST_SHORT;
    end else if (fin_step) begin
      bundle.status = fin_status;
      bundle.count  = count_ext[OUT_COUNT_W-1:0];
      if (fin_elem) begin
        bundle.n       = 2'd2;
        bundle.kind[0] = KIND_ELEM;
        bundle.kind[1] = KIND_STATUS;
      end else begin
        bundle.n       = 2'd1;
        bundle.kind[0] = KIND_STATUS;
      end
    end else if (live) begin
      if (begin_tok || ((phase == PH_TOK) && tk) ||
          ((phase == PH_STR) && !is_q && (text_byte != CH_BSLASH))) begin
        bundle.n       = 2'd1;
        bundle.kind[0] = KIND_DATA;
        bundle.data[0] = text_byte;
      end else if ((phase == PH_ESC) && esc_dec[8]) begin
        bundle.n       = 2'd1;
        bundle.kind[0] = KIND_DATA;
        bundle.data[0] = esc_dec[7:0];
      end else if (key_colon) begin
        bundle.n       = 2'd1;
        bundle.kind[0] = KIND_KEY;
      end else if (val_comma) begin
        bundle.n       = 2'd1;
        bundle.kind[0] = KIND_ELEM;
      end else if (hex_last) begin
        // utf-8 encoding of the escaped code point
        if (uni < 16'h0080) begin
          bundle.n       = 2'd1;
          bundle.data[0] = uni[7:0];
        end else if (uni < 16'h0800) begin
          bundle.n       = 2'd2;
          bundle.data[0] = 8'hC0 | {3'b000, uni[10:6]};
          bundle.data[1] = 8'h80 | {2'b00, uni[5:0]};
        end else begin
          bundle.n       = 2'd3;
          bundle.data[0] = 8'hE0 | {4'h0, uni[15:12]};
          bundle.data[1] = 8'h80 | {2'b00, uni[11:6]};
          bundle.data[2] = 8'h80 | {2'b00, uni[5:0]};
        end
      end
    end
    push = bundle.n != 2'd0;
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_mode      <= 1'b0;
      phase         <= PH_START;
      single_quoted <= 1'b0;
      hex_cnt       <= 2'd0;
      hex_value     <= 16'd0;
      start_bad     <= 1'b0;
      first_error   <= ST_OK;
      count         <= '0;
      in_key        <= 1'b0;
    end else begin
      if (cfg_write) map_mode <= cfg_data;
      phase         <= phase_next;
      single_quoted <= single_quoted_next;
      hex_cnt       <= hex_cnt_next;
      hex_value     <= hex_value_next;
      start_bad     <= start_bad_next;
      first_error   <= first_error_next;
      count         <= count_next;
      in_key        <= in_key_next;
    end
  end

endmodule

// ===== rtl/core/fjt_queue.sv =====
// ----------------------------------------------------------------------------
// fjt_queue
// Short queue of result bundles between parser front and output back end.
// ----------------------------------------------------------------------------
module fjt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fjt_pkg::bundle_t wdata,
  input  logic             pop,
  output fjt_pkg::bundle_t rdata,
  output fjt_pkg::q_stat_t stat
);
  import fjt_pkg::*;

  bundle_t           entries [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   fill;

  // flags and head entry
  always_comb begin
    stat.full  = fill == QDEPTH[QPTR_W:0];
    stat.empty = fill == '0;
    rdata      = entries[rptr];
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= wdata;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

// ===== rtl/core/fjt_back.sv =====
// ----------------------------------------------------------------------------
// fjt_back
// Output back end: walks the head bundle one result per cycle, while the output
// is free, into the output register.
// ----------------------------------------------------------------------------
module fjt_back (
  input  logic             clk,
  input  logic             rst,
  input  fjt_pkg::bundle_t head,
  input  fjt_pkg::q_stat_t stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [3:0]       status,
  output logic [15:0]      element_count,
  output logic             last
);
  import fjt_pkg::*;

  logic [1:0] idx;
  logic       take, is_last, is_status;

  // slot selection
  always_comb begin
    take      = !stat.empty && (!out_valid || out_ready);
    is_last   = idx == (head.n - 2'd1);
    is_status = head.kind[idx] == KIND_STATUS;
    pop       = take && is_last;
  end

  // slot index and valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (take) idx <= is_last ? 2'd0 : idx + 2'd1;
      if (take) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (take) begin
      kind          <= head.kind[idx];
      data_byte     <= head.data[idx];
      status        <= is_status ? head.status : ST_OK;
      element_count <= is_status ? head.count : '0;
      last          <= is_last;
    end
  end

endmodule

// ===== rtl/core/flat_json_list_map_tokenizer_core.sv =====
// Path: an accepted byte's results go into the queue, then the output register.
// Throughput: one byte per cycle while the queue is not full; one result per
// cycle leaves the output register while out_ready allows, with a four-bundle
// queue absorbing the unicode escapes that expand to three bytes.
// Reset: synchronous rst clears parser state, counters, queue and map_mode;
// no clearing pass.
// ----------------------------------------------------------------------------
// flat_json_list_map_tokenizer_core
// Tokenizer for one flat JSON array or map: parser front end, result queue
// and output back end.
// ----------------------------------------------------------------------------
module flat_json_list_map_tokenizer_core #(
  parameter int COUNT_WIDTH = fjt_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [3:0]  status,
  output logic [15:0] element_count,
  output logic        last
);
  import fjt_pkg::*;

  logic    accept, push, pop;
  bundle_t front_bundle, head;
  q_stat_t qstat;

  // input handshake
  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  // parser front end
  fjt_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .push       (push),
    .bundle     (front_bundle)
  );

  // result queue
  fjt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_bundle),
    .pop   (pop),
    .rdata (head),
    .stat  (qstat)
  );

  // output back end
  fjt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .stat          (qstat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .data_byte     (data_byte),
    .status        (status),
    .element_count (element_count),
    .last          (last)
  );

`ifndef SYNTHESIS
  // status and count only ride on a status result
  a_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_STATUS) |-> (status == ST_OK) && (element_count == '0))
    else $error("status or count set on a non-status result");

  // a status result always closes its request's results
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_STATUS) |-> last)
    else $error("status result not marked last");

  // only data results carry a byte
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_DATA) |-> (data_byte == 8'h00))
    else $error("data byte set on a mark or status result");

  // the back end never drains an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("queue popped while empty");
`endif

endmodule

// ===== dv/flat_json_list_map_tokenizer_core_test.sv =====
// ----------------------------------------------------------------------------
// flat_json_list_map_tokenizer_core_test
// Self-checking bench for the JSON array/map tokenizer. A short stimulus table
// covers brackets, quoting, escapes and status priority. Random documents
// follow: mostly well-formed ones with random content, plus mutated, truncated
// and noisy ones. Every result is compared against a behavioral predictor of
// the parser, or for typed table rows against the status read off by hand.
// ----------------------------------------------------------------------------
module flat_json_list_map_tokenizer_core_test;
  import fjt_pkg::*;

  // one expected or observed result
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [3:0]  st;
    logic [15:0] cnt;
    logic        last;
  } tok_res_t;

  typedef enum logic {ROW_BYTE, ROW_MODE} row_op_t;

  // stimulus table row; typed rows carry the final status read off by hand
  typedef struct {
    row_op_t     op;
    logic [7:0]  b;
    logic        fin;
    bit          typed;
    logic [3:0]  st;
    logic [15:0] cnt;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  text_byte;
  logic        final_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [3:0]  status;
  logic [15:0] element_count;
  logic        last;

  flat_json_list_map_tokenizer_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .text_byte     (text_byte),
    .final_byte    (final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .data_byte     (data_byte),
    .status        (status),
    .element_count (element_count),
    .last          (last)
  );

  // parser state mirror
  phase_t      ph;
  logic        mode_q;
  logic        sq_flag;
  logic        key_flag;
  logic        bad_open;
  logic [2:0]  hex_cnt;
  logic [15:0] hex_acc;
  logic [3:0]  err_code;
  logic [15:0] elem_cnt;

  tok_res_t    step_res[$];
  tok_res_t    pending_tokens[$];
  logic [7:0]  doc_q[$];

  int          err_cnt;
  int          burst_left;
  int          rx_tick;
  int          rx_style;

  logic [7:0]  esc_list [8] = '{CH_BSLASH, "/", "t", "r", "n", "f", "b", CH_DQUOTE};

  dir_row_t dir_rows [27] = '{
    // final byte as the very first byte
    '{ROW_BYTE, CH_RBRACK, 1'b1, 1'b1, ST_SHORT,       16'd0},
    // single-quoted string with byte extremes and a three-byte unicode escape
    '{ROW_BYTE, CH_LBRACK, 1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, CH_SQUOTE, 1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, 8'h00,     1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, 8'hFF,     1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, CH_BSLASH, 1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, CH_LOW_U,  1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, "F",       1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, "f",       1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, "f",       1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, "f",       1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, CH_SQUOTE, 1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, CH_COMMA,  1'b0, 1'b0, ST_OK,          16'd0},
    // trailing comma is accepted
    '{ROW_BYTE, CH_RBRACK, 1'b1, 1'b1, ST_OK,          16'd1},
    // bad start outranks the rest
    '{ROW_BYTE, "x",       1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, CH_RBRACK, 1'b1, 1'b1, ST_BAD_START,   16'd0},
    // stray comma, then the wrong closer: bad end wins
    '{ROW_BYTE, CH_LBRACK, 1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, CH_COMMA,  1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, CH_RBRACE, 1'b1, 1'b1, ST_BAD_END,     16'd0},
    // map mode: bare key, then a value with a bad escape
    '{ROW_MODE, 8'h01,     1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, CH_LBRACE, 1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, "k",       1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, CH_COLON,  1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, CH_DQUOTE, 1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, CH_BSLASH, 1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, "q",       1'b0, 1'b0, ST_OK,          16'd0},
    '{ROW_BYTE, CH_RBRACE, 1'b1, 1'b1, ST_BAD_ESC,     16'd0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // mismatch report
  task automatic flag_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    if (err_cnt <= 100)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  function automatic bit is_blank(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic bit is_word(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == "_" || c == "-" || c == ".";
  endfunction

  // ---------------------------------------------------------------- predictor

  task automatic add_res(input logic [1:0] k, input logic [7:0] d, input logic [3:0] s,
                         input logic [15:0] c);
    step_res.push_back('{k, d, s, c, 1'b0});
  endtask

  task automatic abort_doc(input logic [3:0] e);
    err_code = e;
    ph = PH_DEAD;
  endtask

  task automatic clear_doc();
    ph       = PH_START;
    sq_flag  = 1'b0;
    hex_cnt  = '0;
    hex_acc  = '0;
    bad_open = 1'b0;
    err_code = ST_OK;
    elem_cnt = '0;
    key_flag = 1'b0;
  endtask

  // element or pair complete, count saturates
  task automatic close_elem();
    if (elem_cnt != 16'hFFFF) elem_cnt++;
    add_res(KIND_ELEM, 8'h00, ST_OK, 16'd0);
  endtask

  // after a key: blanks, then a colon
  task automatic tail_of_key(input logic [7:0] b);
    if (is_blank(b)) ph = PH_AKEY;
    else if (b == CH_COLON) begin
      add_res(KIND_KEY, 8'h00, ST_OK, 16'd0);
      key_flag = 1'b0;
      ph = PH_VAL;
    end else abort_doc(ST_NO_COLON);
  endtask

  // after an element or value: blanks, then a comma
  task automatic tail_of_value(input logic [7:0] b);
    if (is_blank(b)) ph = PH_AVAL;
    else if (b == CH_COMMA) begin
      close_elem();
      ph = PH_ELEM;
    end else abort_doc(ST_NO_COMMA);
  endtask

  // first byte of an element; anything else makes it empty
  task automatic start_elem(input logic [7:0] b);
    if (b == CH_DQUOTE || b == CH_SQUOTE) begin
      sq_flag = (b == CH_SQUOTE);
      ph = PH_STR;
    end else if (is_word(b)) begin
      add_res(KIND_DATA, b, ST_OK, 16'd0);
      ph = PH_TOK;
    end else if (key_flag) tail_of_key(b);
    else tail_of_value(b);
  endtask

  // results caused by one accepted byte, left in step_res
  task automatic predict_byte(input logic [7:0] b, input logic fin);
    logic [7:0]  opener;
    logic [7:0]  closer;
    logic [7:0]  quote;
    logic [3:0]  st;
    logic [3:0]  nib;
    bit          nib_ok;
    logic [15:0] u;
    opener = mode_q ? CH_LBRACE : CH_LBRACK;
    closer = mode_q ? CH_RBRACE : CH_RBRACK;
    quote  = sq_flag ? CH_SQUOTE : CH_DQUOTE;
    step_res = {};
    if (ph == PH_START) begin
      if (fin) add_res(KIND_STATUS, 8'h00, ST_SHORT, 16'd0);
      else if (b != opener) begin
        bad_open = 1'b1;
        ph = PH_DEAD;
      end else begin
        elem_cnt = '0;
        err_code = ST_OK;
        key_flag = 1'b0;
        ph = PH_ELEM;
      end
    end else if (fin) begin
      // status priority: bad start, bad end, then the first parse error
      if (bad_open) st = ST_BAD_START;
      else if (b != closer) st = ST_BAD_END;
      else begin
        case (ph)
          PH_STR:  abort_doc(ST_UNCLOSED);
          PH_ESC:  abort_doc(ST_LONE_BSLASH);
          PH_HEX:  abort_doc(ST_SHORT_UNI);
          PH_TOK:  if (key_flag) abort_doc(ST_NO_COLON); else close_elem();
          PH_AKEY: abort_doc(ST_NO_COLON);
          PH_AVAL, PH_VAL: close_elem();
          default: ;
        endcase
        st = err_code;
      end
      add_res(KIND_STATUS, 8'h00, st, elem_cnt);
      clear_doc();
    end else begin
      case (ph)
        PH_ELEM: begin
          if (b == CH_COMMA) abort_doc(ST_STRAY_COMMA);
          else if (!is_blank(b)) begin
            key_flag = mode_q;
            start_elem(b);
          end
        end
        PH_VAL: begin
          if (!is_blank(b)) begin
            key_flag = 1'b0;
            start_elem(b);
          end
        end
        PH_STR: begin
          if (b == quote) ph = key_flag ? PH_AKEY : PH_AVAL;
          else if (b == CH_BSLASH) ph = PH_ESC;
          else add_res(KIND_DATA, b, ST_OK, 16'd0);
        end
        PH_ESC: begin
          ph = PH_STR;
          case (b)
            CH_LOW_U: begin
              hex_cnt = '0;
              hex_acc = '0;
              ph = PH_HEX;
            end
            CH_BSLASH, "/", CH_DQUOTE: add_res(KIND_DATA, b, ST_OK, 16'd0);
            "t": add_res(KIND_DATA, 8'h09, ST_OK, 16'd0);
            "r": add_res(KIND_DATA, 8'h0D, ST_OK, 16'd0);
            "n": add_res(KIND_DATA, 8'h0A, ST_OK, 16'd0);
            "f": add_res(KIND_DATA, 8'h0C, ST_OK, 16'd0);
            "b": add_res(KIND_DATA, 8'h08, ST_OK, 16'd0);
            default: abort_doc(ST_BAD_ESC);
          endcase
        end
        PH_HEX: begin
          // hex digit value from the low nibble of the character
          nib_ok = 1'b1;
          nib = b[3:0];
          if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) nib = b[3:0] + 4'd9;
          else if (!(b >= "0" && b <= "9")) nib_ok = 1'b0;
          if (!nib_ok) abort_doc(ST_SHORT_UNI);
          else begin
            hex_acc = {hex_acc[11:0], nib};
            hex_cnt++;
            if (hex_cnt >= 3'd4) begin
              // utf-8 encoding of the code unit
              u = hex_acc;
              if (u < 16'h80) add_res(KIND_DATA, u[7:0], ST_OK, 16'd0);
              else if (u < 16'h800) begin
                add_res(KIND_DATA, {3'b110, u[10:6]}, ST_OK, 16'd0);
                add_res(KIND_DATA, {2'b10, u[5:0]}, ST_OK, 16'd0);
              end else begin
                add_res(KIND_DATA, {4'b1110, u[15:12]}, ST_OK, 16'd0);
                add_res(KIND_DATA, {2'b10, u[11:6]}, ST_OK, 16'd0);
                add_res(KIND_DATA, {2'b10, u[5:0]}, ST_OK, 16'd0);
              end
              hex_cnt = '0;
              ph = PH_STR;
            end
          end
        end
        PH_TOK: begin
          if (is_word(b)) add_res(KIND_DATA, b, ST_OK, 16'd0);
          else if (key_flag) tail_of_key(b);
          else tail_of_value(b);
        end
        PH_AKEY: tail_of_key(b);
        PH_AVAL: tail_of_value(b);
        default: ;
      endcase
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
  endtask

  // ------------------------------------------------------------------ sender

  // one request, with burst/gap idling in front of it
  task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
                           input tok_res_t typed_res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    text_byte  <= b;
    final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    predict_byte(b, fin);
    if (typed) pending_tokens.push_back(typed_res);
    else foreach (step_res[k]) pending_tokens.push_back(step_res[k]);
  endtask

  task automatic pause_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // map_mode write once the block has drained
  task automatic set_map_mode(input logic m);
    pause_input();
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    mode_q = m;
  endtask

  // random string or bare token into doc_q
  task automatic add_item();
    logic [7:0]  q;
    logic [7:0]  c;
    logic [15:0] u;
    logic [3:0]  nib;
    int          len;
    if ($urandom_range(0, 2) == 0) begin
      len = $urandom_range(1, 4);
      repeat (len) begin
        do c = 8'($urandom_range(0, 255)); while (!is_word(c));
        doc_q.push_back(c);
      end
    end else begin
      q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      doc_q.push_back(q);
      len = $urandom_range(0, 5);
      repeat (len) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            doc_q.push_back(CH_BSLASH);
            doc_q.push_back(esc_list[$urandom_range(0, 7)]);
          end
          2: begin
            // unicode escape, one of the three encoded lengths
            case ($urandom_range(0, 2))
              0:       u = 16'($urandom_range(0, 16'h7F));
              1:       u = 16'($urandom_range(16'h80, 16'h7FF));
              default: u = 16'($urandom_range(16'h800, 16'hFFFF));
            endcase
            doc_q.push_back(CH_BSLASH);
            doc_q.push_back(CH_LOW_U);
            for (int j = 3; j >= 0; j--) begin
              nib = u[j*4 +: 4];
              if (nib < 4'd10) doc_q.push_back(8'h30 + nib);
              else doc_q.push_back(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10);
            end
          end
          default: begin
            do c = 8'($urandom_range(0, 255)); while (c == q || c == CH_BSLASH);
            doc_q.push_back(c);
          end
        endcase
      end
      doc_q.push_back(q);
    end
  endtask

  task automatic add_blank();
    case ($urandom_range(0, 15))
      0: doc_q.push_back(" ");
      1: doc_q.push_back(8'h09);
      2: doc_q.push_back(8'h0D);
      3: doc_q.push_back(8'h0A);
      default: ;
    endcase
  endtask

  // one document in doc_q: mostly well-formed, some broken on purpose
  task automatic make_doc(input logic m);
    logic [7:0] opener;
    logic [7:0] closer;
    int         n;
    int         k;
    opener = m ? CH_LBRACE : CH_LBRACK;
    closer = m ? CH_RBRACE : CH_RBRACK;
    doc_q = {};
    doc_q.push_back(opener);
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      add_blank();
      add_item();
      if (m) begin
        add_blank();
        doc_q.push_back(CH_COLON);
        add_blank();
        // an empty value now and then
        if ($urandom_range(0, 6) != 0) add_item();
      end
      add_blank();
      if (i < n - 1 || $urandom_range(0, 3) == 0) doc_q.push_back(CH_COMMA);
    end
    doc_q.push_back(closer);
    case ($urandom_range(0, 13))
      // one byte replaced by noise
      0: doc_q[$urandom_range(1, doc_q.size() - 2)] = 8'($urandom_range(0, 255));
      // cut short, then closed: ends inside strings, escapes, keys
      1, 2: begin
        k = $urandom_range(1, doc_q.size() - 1);
        while (doc_q.size() > k) void'(doc_q.pop_back());
        doc_q.push_back(closer);
      end
      // wrong final byte
      3: doc_q[doc_q.size() - 1] = 8'($urandom_range(0, 255));
      // random bytes
      4: begin
        doc_q = {};
        repeat ($urandom_range(1, 8)) doc_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) doc_q[0] = opener;
        doc_q.push_back($urandom_range(0, 1) ? closer : 8'($urandom_range(0, 255)));
      end
      // single final byte
      5: begin
        doc_q = {};
        doc_q.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- receiver

  // stall pattern and result check
  always @(posedge clk) begin : rx_side
    tok_res_t want;
    logic     rdy_next;
    if (!rst && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) flag_mismatch("result with none pending, kind", kind, -1);
      else begin
        want = pending_tokens.pop_front();
        if (kind !== want.kind) flag_mismatch("kind", kind, want.kind);
        if (data_byte !== want.data) flag_mismatch("data_byte", data_byte, want.data);
        if (status !== want.st) flag_mismatch("status", status, want.st);
        if (element_count !== want.cnt)
          flag_mismatch("element_count", element_count, want.cnt);
        if (last !== want.last) flag_mismatch("last", last, want.last);
      end
    end
    rx_tick++;
    if (rx_tick % 50 == 0) rx_style = $urandom_range(0, 3);
    case (rx_style)
      0:       rdy_next = 1'b1;
      1:       rdy_next = 1'($urandom_range(0, 1));
      2:       rdy_next = (rx_tick % 7) >= 3;
      default: rdy_next = ($urandom_range(0, 7) != 0);
    endcase
    out_ready <= rdy_next;
  end

  // -------------------------------------------------------------------- main

  initial begin
    int hold_at;
    int rand_items;
    int doc_no;
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_data   <= 1'b0;
    in_valid   <= 1'b0;
    text_byte  <= 8'h00;
    final_byte <= 1'b0;
    out_ready  <= 1'b0;
    err_cnt    = 0;
    burst_left = 0;
    rx_tick    = 0;
    rx_style   = 0;
    mode_q     = 1'b0;
    clear_doc();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // stimulus table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_MODE) set_map_mode(dir_rows[i].b[0]);
      else send_byte(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].typed,
                     '{KIND_STATUS, 8'h00, dir_rows[i].st, dir_rows[i].cnt, 1'b1});
    end

    // random documents
    rand_items = 0;
    doc_no = 0;
    while (rand_items < 150) begin
      if (doc_no < 2) set_map_mode(doc_no[0]);
      else if ($urandom_range(0, 2) == 0) set_map_mode(1'($urandom_range(0, 1)));
      make_doc(mode_q);
      hold_at = -1;
      if (doc_no == 2) hold_at = doc_q.size() / 2;
      else if ($urandom_range(0, 7) == 0) hold_at = $urandom_range(0, doc_q.size() - 1);
      foreach (doc_q[i]) begin
        // sender holds off until every pending result is out
        if (i == hold_at) begin
          pause_input();
          while (pending_tokens.size() != 0) @(posedge clk);
        end
        send_byte(doc_q[i], i == doc_q.size() - 1, 1'b0, '0);
      end
      rand_items += doc_q.size();
      doc_no++;
    end

    // drain
    pause_input();
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
